### hw/rtl/bitmap_key_allocator_assert.svh
// ----------------------------------------------------------------------------
// bitmap key allocator assertion macros
// shared property forms for the allocator's concurrent checks
// ----------------------------------------------------------------------------
`ifndef BITMAP_KEY_ALLOCATOR_ASSERT_SVH
`define BITMAP_KEY_ALLOCATOR_ASSERT_SVH

// same-cycle implication, off while reset is high
`define BKA_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bitmap key allocator check failed");

// next-cycle implication, off while reset is high
`define BKA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bitmap key allocator check failed");

`endif

### hw/rtl/bka_pkg.sv
// ----------------------------------------------------------------------------
// bka_pkg
// types and fixed constants of the bitmap key allocator
// ----------------------------------------------------------------------------
package bka_pkg;

  localparam int KEY_W = 32;
  localparam int OBJ_W = 32;
  localparam int CFG_W = 11;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  // register indexes of the config port
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_OFFSET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RESERVED_KEYS = 2'd2;

  // register reset values
  localparam logic [KEY_W-1:0] KEY_OFFSET_RST = '0;
  localparam logic [CFG_W-1:0] KEY_COUNT_RST = 11'd1024;
  localparam logic [CFG_W-1:0] RESERVED_KEYS_RST = '0;

  // request kinds
  localparam logic REQ_ENTER = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EXISTS   = 2'd1,
    ST_NOSPACE  = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_REM_WR,
    S_ENT_CHK,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_DRAW,
    S_PUSH
  } fsm_state_t;

endpackage

### hw/rtl/bka_ram.sv
// ----------------------------------------------------------------------------
// bka_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module bka_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/bka_lsb.sv
// ----------------------------------------------------------------------------
// bka_lsb
// lowest set bit finder over one bitmap word
// ----------------------------------------------------------------------------
module bka_lsb #(
  parameter int WORD_BITS = 64
) (
  input  logic [WORD_BITS-1:0]         word,
  output logic                         found,
  output logic [$clog2(WORD_BITS)-1:0] index
);

  localparam int LO_W = $clog2(WORD_BITS);

  logic [WORD_BITS-1:0] iso;

  // isolate the lowest one by anding the word with its two's complement
  assign iso = word & (~word + WORD_BITS'(1));
  assign found = |word;

  // encode the one-hot word, each index bit is an or over its positions
  always_comb begin
    index = '0;
    for (int b = 0; b < LO_W; b++) begin
      for (int i = 0; i < WORD_BITS; i++) begin
        if (((i >> b) & 1) == 1) begin
          index[b] = index[b] | iso[i];
        end
      end
    end
  end

endmodule

### hw/rtl/bitmap_key_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_key_allocator
// key allocator over a free bitmap and an object store, run by a sequencer
// ----------------------------------------------------------------------------
//  channel   direction  handshake               payload
//  s_axis    in         s_axis_tvalid/tready    tuser req_type, tdata key, object_value
//  m_axis    out        m_axis_tvalid/tready    tuser status, tdata key_out
//  cfg       in         cfg_valid/cfg_ready     cfg_index, cfg_data
//
// after reset a clearing pass over all MAX_KEYS slots zeroes the object store and
// fills the bitmap words with ones; no beat is taken meanwhile
// key in range: decode, remove write or enter check, output register; refused draw or missed
// remove: decode, output register; draw: read and check of each bitmap word scanned from the
// first unreserved word, draw if a bit is free; a new beat is taken while the last result
// waits on m_axis; the user must set WORD_BITS and MAX_KEYS (unchecked) to powers of two
// ----------------------------------------------------------------------------
module bitmap_key_allocator #(
  parameter int MAX_KEYS = 1024,
  parameter int WORD_BITS = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  // input beat
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [63:0]                        s_axis_tdata,  // key[31:0], object_value[63:32]
  input  logic                               s_axis_tuser,  // req_type
  // result beat
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [31:0]                        m_axis_tdata,  // key_out[31:0]
  output logic [1:0]                         m_axis_tuser,  // status[1:0]
  // config writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [bka_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bka_pkg::CFG_DATA_W-1:0]     cfg_data
);

  import bka_pkg::*;

  localparam int NWORDS = MAX_KEYS / WORD_BITS;
  localparam int LO_W = $clog2(WORD_BITS);
  localparam int SW = $clog2(MAX_KEYS);
  localparam int HI_W = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int HC_W = $clog2(NWORDS + 1);
  localparam int NW_RAW = $clog2(MAX_KEYS + 1);
  localparam int NW = (NW_RAW > CFG_W) ? NW_RAW : CFG_W;
  localparam int RW = CFG_W + 1;

  // config registers
  logic [KEY_W-1:0] key_offset;
  logic [CFG_W-1:0] key_count;
  logic [CFG_W-1:0] reserved_keys;

  // sequencer and item registers
  fsm_state_t       state, state_next;
  logic [SW-1:0]    clr_cnt;
  logic             req_type;
  logic [KEY_W-1:0] req_key;
  logic [OBJ_W-1:0] req_obj;
  logic [SW-1:0]    slot;
  logic [HC_W-1:0]  hi_cnt;
  logic [LO_W-1:0]  lo_reg;
  logic [WORD_BITS-1:0] word_reg;
  logic [NW-1:0]    drawn_count;
  status_t          res_status;
  logic [KEY_W-1:0] res_key;
  logic             out_valid;
  status_t          out_status;
  logic [KEY_W-1:0] out_key;

  // ram ports
  logic                 obj_we;
  logic [SW-1:0]        obj_waddr, obj_raddr;
  logic [OBJ_W-1:0]     obj_wdata, obj_rdata;
  logic                 bm_we;
  logic [HI_W-1:0]      bm_waddr, bm_raddr;
  logic [WORD_BITS-1:0] bm_wdata, bm_rdata;

  // decode signals
  logic [NW-1:0]    eff_n;
  logic [KEY_W:0]   diff;
  logic             in_range;
  logic [SW-1:0]    dec_slot;
  logic [RW-1:0]    rwords;
  logic             res_full;
  logic             lsb_found;
  logic [LO_W-1:0]  lsb_index;
  logic [SW-1:0]    draw_slot;
  logic             draw_fits;
  logic             push_go;
  logic             clr_done;

  // key range decode
  assign eff_n = (NW'(key_count) > NW'(MAX_KEYS)) ? NW'(MAX_KEYS) : NW'(key_count);
  assign diff = {req_key[KEY_W-1], req_key} - {key_offset[KEY_W-1], key_offset};
  assign in_range = !diff[KEY_W] && (diff < (KEY_W + 1)'(eff_n));
  assign dec_slot = diff[SW-1:0];
  assign rwords = (RW'(reserved_keys) + RW'(WORD_BITS - 1)) >> LO_W;
  assign res_full = rwords >= RW'(NWORDS);

  // draw candidate from the scanned word
  assign draw_slot = (SW'(hi_cnt) << LO_W) | SW'(lo_reg);
  assign draw_fits = NW'(draw_slot) < eff_n;
  assign push_go = !out_valid || m_axis_tready;
  assign clr_done = clr_cnt == SW'(MAX_KEYS - 1);

  bka_ram #(.WIDTH(OBJ_W), .DEPTH(MAX_KEYS)) u_obj_ram (
    .clk   (clk),
    .we    (obj_we),
    .waddr (obj_waddr),
    .wdata (obj_wdata),
    .raddr (obj_raddr),
    .rdata (obj_rdata)
  );

  bka_ram #(.WIDTH(WORD_BITS), .DEPTH(NWORDS)) u_bm_ram (
    .clk   (clk),
    .we    (bm_we),
    .waddr (bm_waddr),
    .wdata (bm_wdata),
    .raddr (bm_raddr),
    .rdata (bm_rdata)
  );

  bka_lsb #(.WORD_BITS(WORD_BITS)) u_lsb (
    .word  (bm_rdata),
    .found (lsb_found),
    .index (lsb_index)
  );

  // config port, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_offset <= KEY_OFFSET_RST;
      key_count <= KEY_COUNT_RST;
      reserved_keys <= RESERVED_KEYS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_KEY_OFFSET:    key_offset <= cfg_data;
        CFG_KEY_COUNT:     key_count <= cfg_data[CFG_W-1:0];
        CFG_RESERVED_KEYS: reserved_keys <= cfg_data[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (s_axis_tvalid) state_next = S_DECODE;
      end
      S_DECODE: begin
        if (req_type == REQ_REMOVE) begin
          state_next = in_range ? S_REM_WR : S_PUSH;
        end else if (in_range) begin
          state_next = S_ENT_CHK;
        end else if (drawn_count >= eff_n || res_full) begin
          state_next = S_PUSH;
        end else begin
          state_next = S_SCAN_RD;
        end
      end
      S_REM_WR:  state_next = S_PUSH;
      S_ENT_CHK: state_next = S_PUSH;
      S_SCAN_RD: state_next = S_SCAN_CHK;
      S_SCAN_CHK: begin
        if (lsb_found) begin
          state_next = S_DRAW;
        end else if (hi_cnt == HC_W'(NWORDS - 1)) begin
          state_next = S_PUSH;
        end else begin
          state_next = S_SCAN_RD;
        end
      end
      S_DRAW: state_next = S_PUSH;
      S_PUSH: begin
        if (push_go) state_next = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  // ram controls and handshake outputs
  always_comb begin
    obj_we = 1'b0;
    obj_waddr = slot;
    obj_wdata = req_obj;
    obj_raddr = slot;
    bm_we = 1'b0;
    bm_waddr = HI_W'(slot >> LO_W);
    bm_wdata = bm_rdata;
    bm_raddr = HI_W'(hi_cnt);
    s_axis_tready = 1'b0;
    case (state)
      S_CLEAR: begin
        obj_we = 1'b1;
        obj_waddr = clr_cnt;
        obj_wdata = '0;
        bm_we = clr_cnt < SW'(NWORDS);
        bm_waddr = HI_W'(clr_cnt);
        bm_wdata = {WORD_BITS{1'b1}};
      end
      S_IDLE: begin
        s_axis_tready = 1'b1;
      end
      S_DECODE: begin
        obj_raddr = dec_slot;
        bm_raddr = HI_W'(dec_slot >> LO_W);
        obj_waddr = dec_slot;
        obj_wdata = '0;
        obj_we = (req_type == REQ_REMOVE) && in_range;
      end
      S_REM_WR: begin
        bm_we = 1'b1;
        bm_wdata = bm_rdata | (WORD_BITS'(1) << slot[LO_W-1:0]);
      end
      S_ENT_CHK: begin
        obj_we = obj_rdata == '0;
      end
      S_DRAW: begin
        obj_we = draw_fits;
        obj_waddr = draw_slot;
        bm_we = draw_fits;
        bm_waddr = HI_W'(hi_cnt);
        bm_wdata = word_reg & ~(WORD_BITS'(1) << lo_reg);
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_cnt <= '0;
      drawn_count <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_cnt <= clr_cnt + SW'(1);
      // drawn count floors at zero on remove
      if (state == S_REM_WR && drawn_count != '0) drawn_count <= drawn_count - NW'(1);
      if (state == S_DRAW && draw_fits) drawn_count <= drawn_count + NW'(1);
      if (state == S_PUSH && push_go) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // item and result payload
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      req_type <= s_axis_tuser;
      req_key <= s_axis_tdata[31:0];
      req_obj <= s_axis_tdata[63:32];
    end
    case (state)
      S_DECODE: begin
        slot <= dec_slot;
        hi_cnt <= HC_W'(rwords);
        res_key <= '0;
        if (req_type == REQ_REMOVE) begin
          res_status <= in_range ? ST_OK : ST_NOTFOUND;
        end else begin
          res_status <= ST_NOSPACE;
        end
      end
      S_ENT_CHK: begin
        if (obj_rdata == '0) begin
          res_status <= ST_OK;
          res_key <= key_offset + KEY_W'(slot);
        end else begin
          res_status <= ST_EXISTS;
        end
      end
      S_SCAN_CHK: begin
        lo_reg <= lsb_index;
        word_reg <= bm_rdata;
        if (!lsb_found) hi_cnt <= hi_cnt + HC_W'(1);
      end
      S_DRAW: begin
        if (draw_fits) begin
          res_status <= ST_OK;
          res_key <= key_offset + KEY_W'(draw_slot);
        end
      end
      S_PUSH: begin
        if (push_go) begin
          out_status <= res_status;
          out_key <= res_key;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata = out_key;
  assign m_axis_tuser = out_status;

  // checks
  `include "bitmap_key_allocator_assert.svh"

  `BKA_ASSERT_NOW(a_err_key_zero, clk, rst, m_axis_tvalid && m_axis_tuser != ST_OK, m_axis_tdata == '0)
  `BKA_ASSERT_NOW(a_drawn_bound, clk, rst, 1'b1, drawn_count <= NW'(MAX_KEYS))
  `BKA_ASSERT_NOW(a_scan_bound, clk, rst, state == S_SCAN_RD || state == S_SCAN_CHK, hi_cnt < HC_W'(NWORDS))
  `BKA_ASSERT_NEXT(a_draw_count, clk, rst, state == S_DRAW && draw_fits, drawn_count == $past(drawn_count) + NW'(1))

endmodule
